FILE: hdl/hcpd_pkg.sv
`timescale 1ns / 1ps

package hcpd_pkg;

    // timing and valve geometry
    localparam int CONTROL_PERIOD_MS = 10000;
    localparam int OUTPUT_PERIOD_MS  = 1000;
    localparam int VALVE_TRAVEL_MS   = 120000;
    localparam int POS_OPEN          = 25600;
    localparam int POS_CLOSE         = 0;
    localparam int CURVE_BASE        = 5120;   // 20.0 degC in Q8.8
    localparam int POS_STEP          =
        OUTPUT_PERIOD_MS * (POS_OPEN - POS_CLOSE) / VALVE_TRAVEL_MS;
    // control ticks spent in the reference phase
    localparam int REF_TICKS         =
        (VALVE_TRAVEL_MS + CONTROL_PERIOD_MS - 1) / CONTROL_PERIOD_MS;

    // serial multiplier / divider sizes
    localparam int MUL_AW = 35;
    localparam int MUL_BW = 18;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int DIV_NW = 32;
    localparam int DIV_DW = 17;

    typedef enum logic [1:0] {
        CMD_CONTROL = 2'd0,
        CMD_OUTPUT  = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        DRV_STOP  = 2'd0,
        DRV_OPEN  = 2'd1,
        DRV_CLOSE = 2'd2
    } t_drive;

    typedef enum logic [2:0] {
        CFG_DAY     = 3'd0,
        CFG_NIGHT   = 3'd1,
        CFG_INCL    = 3'd2,
        CFG_SLOPE   = 3'd3,
        CFG_KP      = 3'd4,
        CFG_KD      = 3'd5,
        CFG_OVERRUN = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_AB,
        ST_DIV,
        ST_TARGET,
        ST_SLOPE,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_D,
        ST_SUM,
        ST_MUL_S,
        ST_PULSE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] outdoor_temp;
        logic signed [15:0] flow_temp;
        logic               is_night;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] setpoint;
        logic signed [15:0] valve_position;
        logic [1:0]         drive;
        logic signed [31:0] pending_pulse;
        logic [15:0]        direction_changes;
        logic               reference_active;
    } t_out_word;

    function automatic logic signed [15:0] sat16(input logic signed [37:0] v);
        if (v > 38'sd32767) begin
            return 16'sh7fff;
        end else if (v < -38'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -38'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

FILE: hdl/hcpd_mul.sv
`timescale 1ns / 1ps

// shift-add multiplier, one multiplier bit per cycle
module hcpd_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hcpd_pkg::MUL_AW-1:0] i_a,
    input  logic [hcpd_pkg::MUL_BW-1:0] i_b,
    output logic                        o_done,
    output logic [hcpd_pkg::MUL_PW-1:0] o_prod
);
    localparam int CW = $clog2(hcpd_pkg::MUL_BW);

    logic [hcpd_pkg::MUL_AW-1:0] r_a;
    logic [hcpd_pkg::MUL_AW-1:0] r_hi;
    logic [hcpd_pkg::MUL_BW-1:0] r_lo;
    logic [CW-1:0]               r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [hcpd_pkg::MUL_AW:0]   n_sum;

    assign n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(hcpd_pkg::MUL_BW - 1));
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(hcpd_pkg::MUL_BW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= n_sum[hcpd_pkg::MUL_AW:1];
            r_lo <= {n_sum[0], r_lo[hcpd_pkg::MUL_BW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

FILE: hdl/hcpd_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module hcpd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hcpd_pkg::DIV_NW-1:0] i_num,
    input  logic [hcpd_pkg::DIV_DW-1:0] i_den,
    output logic                        o_done,
    output logic [hcpd_pkg::DIV_NW-1:0] o_quo
);
    localparam int CW = $clog2(hcpd_pkg::DIV_NW);

    logic [hcpd_pkg::DIV_DW-1:0] r_den;
    logic [hcpd_pkg::DIV_DW-1:0] r_rem;
    logic [hcpd_pkg::DIV_NW-1:0] r_q;
    logic [CW-1:0]               r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [hcpd_pkg::DIV_DW:0]   n_trial;
    logic [hcpd_pkg::DIV_DW:0]   n_diff;

    assign n_trial = {r_rem, r_q[hcpd_pkg::DIV_NW-1]};
    assign n_diff  = n_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(hcpd_pkg::DIV_NW - 1));
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(hcpd_pkg::DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= i_num;
        end else if (r_busy) begin
            if (n_trial >= {1'b0, r_den}) begin
                r_rem <= n_diff[hcpd_pkg::DIV_DW-1:0];
                r_q   <= {r_q[hcpd_pkg::DIV_NW-2:0], 1'b1};
            end else begin
                r_rem <= n_trial[hcpd_pkg::DIV_DW-1:0];
                r_q   <= {r_q[hcpd_pkg::DIV_NW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

FILE: hdl/heating_curve_pd_valve_controller.sv
`timescale 1ns / 1ps

// Weather-compensated heating controller with a PD law for a three-point valve.
// Each accepted word carries a command: 0 control tick, 1 output tick, 2 clear
// the direction change count (3 only reports). Every word returns one result
// word with the setpoint, estimated valve position, drive, pending pulse time,
// direction change count and reference flag. Output ticks, clears and control
// ticks during the reference phase go straight from acceptance to the done
// state. A full control tick runs four serial multiplies (one for the heating
// curve, three for the PD law and its time scaling), a serial divide (skipped
// when the divisor is zero), and six further steps: target, slope, error, sum,
// pulse and done. One word is worked on at a time; a finished result waits in
// the output register while the next word is taken in.
// Temperatures are Q8.8 degC; the user must write configuration only while
// idle, and the block itself does not enforce this.
module heating_curve_pd_valve_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hcpd_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hcpd_pkg::t_out_word o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    // configuration
    logic [14:0] r_day, r_night, r_incl;
    logic [11:0] r_slope;
    logic [15:0] r_kp, r_kd;
    logic [12:0] r_overrun;

    // controller state
    logic signed [15:0] r_setpoint;
    logic signed [16:0] r_last_err;
    logic signed [31:0] r_pulse;
    logic               r_keep, r_inprog, r_opening, r_moving, r_ref;
    logic [15:0]        r_ref_ticks;
    logic signed [15:0] r_pos;
    logic [15:0]        r_changes;

    // datapath
    logic signed [15:0] r_flow;
    logic [14:0]        r_off;
    logic               r_num_neg, r_den_neg, r_den_zero;
    logic [16:0]        r_den_mag;
    logic signed [33:0] r_quo;
    logic signed [15:0] r_target;
    logic signed [16:0] r_err;
    logic signed [17:0] r_de;
    logic signed [35:0] r_sum;
    logic signed [31:0] r_inc;

    hcpd_pkg::t_state   r_state, n_state;
    logic               r_out_valid;
    hcpd_pkg::t_out_word r_out;

    logic                         accept;
    logic                         mul_start, mul_done, div_done;
    logic                         r_div_go;
    logic [hcpd_pkg::MUL_AW-1:0]  mul_a;
    logic [hcpd_pkg::MUL_BW-1:0]  mul_b;
    logic [hcpd_pkg::MUL_PW-1:0]  mul_p;
    logic [hcpd_pkg::DIV_NW-1:0]  div_q;
    logic                         out_free;

    // heating curve operands, formed combinationally from the input word and configuration
    logic signed [16:0] hc_a;
    logic signed [17:0] hc_b, hc_h, hc_half, hc_den;
    logic [14:0]        hc_off;
    logic [16:0]        hc_a_mag;
    logic [17:0]        hc_b_mag, hc_den_mag;

    // PD operands
    logic signed [16:0] pd_err;
    logic signed [17:0] pd_de;
    logic [16:0]        pd_err_mag;
    logic [17:0]        pd_de_mag;
    logic [35:0]        pd_sum_mag;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != hcpd_pkg::ST_IDLE);
    assign accept     = i_in_valid && (r_state == hcpd_pkg::ST_IDLE);

    assign hc_off     = i_in_data.is_night ? r_night : r_day;
    assign hc_a       = $signed({2'b00, r_incl}) - 17'(hcpd_pkg::CURVE_BASE);
    assign hc_b       = $signed({3'b000, hc_off}) - 18'(i_in_data.outdoor_temp);
    assign hc_h       = 18'(i_in_data.outdoor_temp) - $signed({3'b000, hc_off});
    assign hc_half    = hc_h >>> 1;
    assign hc_den     = 18'(hcpd_pkg::CURVE_BASE) - hc_half;
    assign hc_a_mag   = hc_a[16] ? 17'(-hc_a) : 17'(hc_a);
    assign hc_b_mag   = hc_b[17] ? 18'(-hc_b) : 18'(hc_b);
    assign hc_den_mag = hc_den[17] ? 18'(-hc_den) : 18'(hc_den);

    assign pd_err     = 17'(r_setpoint) - 17'(r_flow);
    assign pd_de      = 18'(pd_err) - 18'(r_last_err);
    assign pd_err_mag = pd_err[16] ? 17'(-pd_err) : 17'(pd_err);
    assign pd_de_mag  = r_de[17] ? 18'(-r_de) : 18'(r_de);
    assign pd_sum_mag = r_sum[35] ? 36'(-r_sum) : 36'(r_sum);

    hcpd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    hcpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_quo[hcpd_pkg::DIV_NW-1:0]),
        .i_den   (r_den_mag),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    // sequencer: next state and unit launches
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            hcpd_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = hcpd_pkg::ST_DONE;
                    if ((hcpd_pkg::t_cmd'(i_in_data.command) == hcpd_pkg::CMD_CONTROL) &&
                        !(r_ref && (r_ref_ticks < 16'(hcpd_pkg::REF_TICKS)))) begin
                        n_state   = hcpd_pkg::ST_MUL_AB;
                        mul_start = 1'b1;
                        mul_a     = hcpd_pkg::MUL_AW'(hc_b_mag);
                        mul_b     = hcpd_pkg::MUL_BW'(hc_a_mag);
                    end
                end
            end
            hcpd_pkg::ST_MUL_AB: begin
                if (mul_done) begin
                    n_state = r_den_zero ? hcpd_pkg::ST_TARGET : hcpd_pkg::ST_DIV;
                end
            end
            hcpd_pkg::ST_DIV: begin
                // numerator magnitude sits in r_quo until the quotient replaces it
                if (div_done) begin
                    n_state = hcpd_pkg::ST_TARGET;
                end
            end
            hcpd_pkg::ST_TARGET: n_state = hcpd_pkg::ST_SLOPE;
            hcpd_pkg::ST_SLOPE:  n_state = hcpd_pkg::ST_ERR;
            hcpd_pkg::ST_ERR: begin
                n_state   = hcpd_pkg::ST_MUL_P;
                mul_start = 1'b1;
                mul_a     = hcpd_pkg::MUL_AW'(r_kp);
                mul_b     = hcpd_pkg::MUL_BW'(pd_err_mag);
            end
            hcpd_pkg::ST_MUL_P: begin
                if (mul_done) begin
                    n_state   = hcpd_pkg::ST_MUL_D;
                    mul_start = 1'b1;
                    mul_a     = hcpd_pkg::MUL_AW'(r_kd);
                    mul_b     = pd_de_mag;
                end
            end
            hcpd_pkg::ST_MUL_D: begin
                if (mul_done) begin
                    n_state = hcpd_pkg::ST_SUM;
                end
            end
            hcpd_pkg::ST_SUM: begin
                n_state   = hcpd_pkg::ST_MUL_S;
                mul_start = 1'b1;
                mul_a     = pd_sum_mag[hcpd_pkg::MUL_AW-1:0];
                mul_b     = hcpd_pkg::MUL_BW'(hcpd_pkg::CONTROL_PERIOD_MS);
            end
            hcpd_pkg::ST_MUL_S: begin
                if (mul_done) begin
                    n_state = hcpd_pkg::ST_PULSE;
                end
            end
            hcpd_pkg::ST_PULSE: n_state = hcpd_pkg::ST_DONE;
            hcpd_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = hcpd_pkg::ST_IDLE;
                end
            end
            default: n_state = hcpd_pkg::ST_IDLE;
        endcase
    end

    // divider launched by a registered start once the numerator has landed in r_quo
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= (r_state == hcpd_pkg::ST_MUL_AB) && mul_done && !r_den_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcpd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output tick
    logic signed [16:0] ot_step;
    logic signed [15:0] ot_pos1;
    logic signed [17:0] ot_lim_hi, ot_lim_lo;
    logic               ot_big;
    logic signed [15:0] n_pos;
    logic signed [31:0] n_pulse;
    logic               n_inprog, n_opening, n_moving;
    logic [15:0]        n_changes;

    assign ot_step   = r_opening ? 17'(r_pos) + 17'(hcpd_pkg::POS_STEP)
                                 : 17'(r_pos) - 17'(hcpd_pkg::POS_STEP);
    assign ot_pos1   = r_inprog ? hcpd_pkg::sat16(38'(ot_step)) : r_pos;
    assign ot_lim_hi = 18'(hcpd_pkg::POS_OPEN) + $signed({5'b0, r_overrun});
    assign ot_lim_lo = 18'(hcpd_pkg::POS_CLOSE) - $signed({5'b0, r_overrun});
    assign ot_big    = (r_pulse >= 32'(hcpd_pkg::OUTPUT_PERIOD_MS)) ||
                       (r_pulse <= -32'(hcpd_pkg::OUTPUT_PERIOD_MS));

    always_comb begin
        n_pos     = ot_pos1;
        n_pulse   = r_pulse;
        n_inprog  = 1'b0;
        n_opening = r_opening;
        n_moving  = r_moving;
        n_changes = r_changes;
        if (r_ref) begin
            // reference phase: keep closing, hold position at zero
            if (!r_moving || r_opening) begin
                n_changes = r_changes + 1'b1;
            end
            n_moving  = 1'b1;
            n_opening = 1'b0;
            n_pos     = '0;
            n_inprog  = r_inprog;
        end else begin
            if (ot_big) begin
                if ((r_pulse > 32'sd0) && (18'(ot_pos1) < ot_lim_hi)) begin
                    if (!r_moving || !r_opening) begin
                        n_changes = r_changes + 1'b1;
                    end
                    n_moving  = 1'b1;
                    n_opening = 1'b1;
                    n_inprog  = 1'b1;
                    n_pulse   = r_pulse - 32'(hcpd_pkg::OUTPUT_PERIOD_MS);
                    if (ot_pos1 < 16'(hcpd_pkg::POS_CLOSE)) begin
                        n_pos = 16'(hcpd_pkg::POS_CLOSE);
                    end
                end else if ((r_pulse < 32'sd0) && (18'(ot_pos1) > ot_lim_lo)) begin
                    if (!r_moving || r_opening) begin
                        n_changes = r_changes + 1'b1;
                    end
                    n_moving  = 1'b1;
                    n_opening = 1'b0;
                    n_inprog  = 1'b1;
                    n_pulse   = r_pulse + 32'(hcpd_pkg::OUTPUT_PERIOD_MS);
                    if (ot_pos1 > 16'(hcpd_pkg::POS_OPEN)) begin
                        n_pos = 16'(hcpd_pkg::POS_OPEN);
                    end
                end
            end
            if (!n_inprog) begin
                n_moving = 1'b0;
            end
        end
    end

    // control tick arithmetic
    logic signed [34:0] tg_sum;
    logic signed [16:0] sl_diff, sl_lim;
    logic [36:0]        inc_mag;
    logic signed [37:0] inc_s;
    logic signed [32:0] pl_sum;
    logic signed [31:0] pl_new;
    logic signed [35:0] pd_prod;

    assign tg_sum  = $signed({20'b0, r_off}) + 35'(r_quo);
    assign sl_diff = 17'(r_target) - 17'(r_setpoint);
    assign sl_lim  = $signed({5'b0, r_slope});
    assign inc_mag = mul_p[hcpd_pkg::MUL_PW-1:16];
    assign inc_s   = r_sum[35] ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
    assign pl_sum  = 33'(r_pulse) + 33'(r_inc);
    assign pl_new  = r_keep ? hcpd_pkg::sat32(38'(pl_sum)) : r_inc;
    assign pd_prod = $signed(mul_p[35:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= '0;
            r_last_err  <= '0;
            r_pulse     <= '0;
            r_keep      <= 1'b0;
            r_inprog    <= 1'b0;
            r_opening   <= 1'b0;
            r_moving    <= 1'b0;
            r_ref       <= 1'b1;
            r_ref_ticks <= '0;
            r_pos       <= '0;
            r_changes   <= '0;
        end else begin
            if (accept) begin
                unique case (hcpd_pkg::t_cmd'(i_in_data.command))
                    hcpd_pkg::CMD_CONTROL: begin
                        if (r_ref && (r_ref_ticks < 16'(hcpd_pkg::REF_TICKS))) begin
                            r_ref_ticks <= r_ref_ticks + 1'b1;
                        end else begin
                            r_ref <= 1'b0;
                        end
                    end
                    hcpd_pkg::CMD_OUTPUT: begin
                        r_pos     <= n_pos;
                        r_pulse   <= n_pulse;
                        r_inprog  <= n_inprog;
                        r_opening <= n_opening;
                        r_moving  <= n_moving;
                        r_changes <= n_changes;
                    end
                    hcpd_pkg::CMD_CLEAR: r_changes <= '0;
                    default: ;
                endcase
            end
            if (r_state == hcpd_pkg::ST_SLOPE) begin
                if (sl_diff > sl_lim) begin
                    r_setpoint <= r_setpoint + $signed({4'b0, r_slope});
                end else if (sl_diff < -sl_lim) begin
                    r_setpoint <= r_setpoint - $signed({4'b0, r_slope});
                end else begin
                    r_setpoint <= r_target;
                end
            end
            if (r_state == hcpd_pkg::ST_ERR) begin
                r_last_err <= pd_err;
            end
            if (r_state == hcpd_pkg::ST_PULSE) begin
                r_pulse <= pl_new;
                r_keep  <= (pl_new < 32'(hcpd_pkg::OUTPUT_PERIOD_MS)) &&
                           (pl_new > -32'(hcpd_pkg::OUTPUT_PERIOD_MS));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flow     <= i_in_data.flow_temp;
            r_off      <= hc_off;
            r_num_neg  <= hc_a[16] ^ hc_b[17];
            r_den_neg  <= hc_den[17];
            r_den_zero <= (hc_den == 18'sd0);
            r_den_mag  <= hc_den_mag[16:0];
        end
        unique case (r_state)
            hcpd_pkg::ST_MUL_AB: begin
                if (mul_done) begin
                    if (r_den_zero) begin
                        // zero divisor saturates by the numerator sign
                        r_quo <= (r_num_neg && (mul_p[31:0] != '0)) ? -34'sd32768
                                                                     : 34'sd32767;
                    end else begin
                        r_quo <= $signed({2'b00, mul_p[31:0]});
                    end
                end
            end
            hcpd_pkg::ST_DIV: begin
                if (div_done) begin
                    r_quo <= (r_num_neg ^ r_den_neg) ? -$signed({2'b00, div_q})
                                                     : $signed({2'b00, div_q});
                end
            end
            hcpd_pkg::ST_TARGET: r_target <= hcpd_pkg::sat16(38'(tg_sum));
            hcpd_pkg::ST_ERR: begin
                r_err <= pd_err;
                r_de  <= pd_de;
            end
            hcpd_pkg::ST_MUL_P: begin
                if (mul_done) begin
                    r_sum <= r_err[16] ? -pd_prod : pd_prod;
                end
            end
            hcpd_pkg::ST_MUL_D: begin
                if (mul_done) begin
                    r_sum <= r_de[17] ? r_sum - pd_prod : r_sum + pd_prod;
                end
            end
            hcpd_pkg::ST_MUL_S: begin
                if (mul_done) begin
                    r_inc <= hcpd_pkg::sat32(inc_s);
                end
            end
            default: ;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day     <= 15'd5120;
            r_night   <= 15'd4352;
            r_incl    <= 15'd6400;
            r_slope   <= 12'd64;
            r_kp      <= 16'd256;
            r_kd      <= 16'd0;
            r_overrun <= 13'd1280;
        end else if (i_cfg_we) begin
            unique case (hcpd_pkg::t_cfg_idx'(i_cfg_index))
                hcpd_pkg::CFG_DAY:     r_day     <= i_cfg_data[14:0];
                hcpd_pkg::CFG_NIGHT:   r_night   <= i_cfg_data[14:0];
                hcpd_pkg::CFG_INCL:    r_incl    <= i_cfg_data[14:0];
                hcpd_pkg::CFG_SLOPE:   r_slope   <= i_cfg_data[11:0];
                hcpd_pkg::CFG_KP:      r_kp      <= i_cfg_data;
                hcpd_pkg::CFG_KD:      r_kd      <= i_cfg_data;
                hcpd_pkg::CFG_OVERRUN: r_overrun <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == hcpd_pkg::ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == hcpd_pkg::ST_DONE) && out_free) begin
            r_out.setpoint          <= r_setpoint;
            r_out.valve_position    <= r_pos;
            r_out.drive             <= !r_moving ? hcpd_pkg::DRV_STOP :
                                       (r_opening ? hcpd_pkg::DRV_OPEN
                                                  : hcpd_pkg::DRV_CLOSE);
            r_out.pending_pulse     <= r_pulse;
            r_out.direction_changes <= r_changes;
            r_out.reference_active  <= r_ref;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
